### hdl/b2d_pkg.sv
// Shared types and constants for the binary to decimal ASCII converter.
// No dependencies; imported by the shift unit and the top level.
package b2d_pkg;

	// Width of one packed BCD digit.
	localparam int unsigned BCD_W = 4;

	// ASCII code of the character '0', truncated to the 6-bit character field.
	localparam logic [5:0] ASCII_ZERO = 6'd48;

	// Sequencer states, one-hot.
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CONV = 4'b0010,
		ST_SKIP = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

endpackage

### hdl/b2d_dabble_unit.sv
// Shift-and-add-3 step of the double dabble conversion on a packed BCD word.
// Depends on b2d_pkg for the digit width.
module b2d_dabble_unit
	import b2d_pkg::*;
#(
	parameter int unsigned NDIG = 20
) (
	input  logic [NDIG*BCD_W-1:0] bcd,
	input  logic                  shift_in,
	output logic [NDIG*BCD_W-1:0] bcd_next
);

	logic [NDIG*BCD_W-1:0] adjusted;

	// Every digit of five or more gets three added before the shift.
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			if (bcd[i*BCD_W +: BCD_W] >= 4'd5) begin
				adjusted[i*BCD_W +: BCD_W] = bcd[i*BCD_W +: BCD_W] + 4'd3;
			end else begin
				adjusted[i*BCD_W +: BCD_W] = bcd[i*BCD_W +: BCD_W];
			end
		end
	end

	// Shift the corrected word left by one and bring in the next binary bit.
	assign bcd_next = {adjusted[NDIG*BCD_W-2:0], shift_in};

endmodule

### hdl/binary_to_decimal_ascii_top.sv
// Binary to decimal ASCII converter, top level with the conversion sequencer.
// Depends on b2d_pkg and b2d_dabble_unit.
//
// Usage:
//   The slave channel takes one unsigned number per transfer in s_tdata; only
//   the low VALUE_WIDTH bits are used. The master channel then gives the
//   number's decimal digits as ASCII characters, most significant first and
//   without leading zeros, one digit per transfer; m_tlast marks the final
//   digit. A zero gives the single character '0'.
//   Sequence: after an input transfer the shared shift-and-add-3 unit runs
//   once per binary bit. Leading zero digits are then dropped at one per
//   cycle until the first significant digit or the last digit is reached,
//   and each digit is then loaded into the output register whenever that
//   register is free. Dropped zeros and digits together number NDIG (20 at
//   a width of 64). s_tready is high only while the sequencer is idle, so a
//   new number is not taken before the current one has been converted and
//   its final digit loaded; the next number can be taken while the final
//   digit still waits.
//   When the receiver stalls, the current digit holds in the output register
//   and the sequencer waits. Reset empties the output register and returns
//   the sequencer to idle; any conversion in progress is dropped.
module binary_to_decimal_ascii_top
	import b2d_pkg::*;
#(
	parameter int unsigned VALUE_WIDTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // [63:0] value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // [5:0] digit_char, [7:6] zero
	output logic        m_tlast   // last_digit
);

	// Digits needed for the largest value of the given width.
	localparam int unsigned NDIG  = (VALUE_WIDTH * 1233) / 4096 + 1;
	localparam int unsigned BCD_TW = NDIG * BCD_W;
	localparam int unsigned CNT_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
	localparam int unsigned DCNT_W = $clog2(NDIG + 1);

	state_t                   state_q;
	logic [VALUE_WIDTH-1:0]   value_q;
	logic [BCD_TW-1:0]        bcd_q;
	logic [BCD_TW-1:0]        bcd_next;
	logic [CNT_W-1:0]         bit_cnt_q;
	logic [DCNT_W-1:0]        dig_cnt_q;
	logic                     out_valid_q;
	logic [5:0]               out_digit_q;
	logic                     out_last_q;
	logic [BCD_W-1:0]         top_digit;
	logic                     out_free;

	// Shared conversion step.
	b2d_dabble_unit #(
		.NDIG (NDIG)
	) u_unit (
		.bcd      (bcd_q),
		.shift_in (value_q[VALUE_WIDTH-1]),
		.bcd_next (bcd_next)
	);

	assign top_digit = bcd_q[BCD_TW-1 -: BCD_W];
	assign out_free  = !out_valid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE);

	// Sequencer: load, convert bit by bit, drop leading zeros, emit digits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (bit_cnt_q == '0) begin
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					if (top_digit != '0 || dig_cnt_q == DCNT_W'(1)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free && dig_cnt_q == DCNT_W'(1)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers follow the sequencer.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					value_q   <= s_tdata[VALUE_WIDTH-1:0];
					bcd_q     <= '0;
					bit_cnt_q <= CNT_W'(VALUE_WIDTH - 1);
				end
			end
			ST_CONV: begin
				bcd_q     <= bcd_next;
				value_q   <= value_q << 1;
				bit_cnt_q <= bit_cnt_q - CNT_W'(1);
				dig_cnt_q <= DCNT_W'(NDIG);
			end
			ST_SKIP: begin
				if (top_digit == '0 && dig_cnt_q != DCNT_W'(1)) begin
					bcd_q     <= bcd_q << BCD_W;
					dig_cnt_q <= dig_cnt_q - DCNT_W'(1);
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					bcd_q     <= bcd_q << BCD_W;
					dig_cnt_q <= dig_cnt_q - DCNT_W'(1);
				end
			end
			default: begin
				bcd_q <= bcd_q;
			end
		endcase
	end

	// Output register: holds a digit until the receiver takes the transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			out_digit_q <= ASCII_ZERO + {2'b00, top_digit};
			out_last_q  <= (dig_cnt_q == DCNT_W'(1));
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_digit_q};
	assign m_tlast  = out_last_q;

endmodule

### hdl/b2d_checker.sv
// Port-level checks for the binary to decimal ASCII converter.
// Depends only on the top level's ports; bound to binary_to_decimal_ascii_top.
module b2d_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast
);

	logic first_q;

	// Marks that the next output transfer opens a new run of digits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
		end else if (m_tvalid && m_tready) begin
			first_q <= m_tlast;
		end
	end

	// A stalled digit holds its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled output digit changed");

	// After an input transfer the block is busy converting.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted again straight after a transfer");

	// No new input is taken while a run still has digits to come.
	a_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("input ready in the middle of a digit run");

	// A run never opens with a leading zero unless it is the single digit zero.
	a_lead: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && first_q && m_tdata[5:0] == 6'd48 |-> m_tlast)
		else $error("leading zero in a digit run");

endmodule

bind binary_to_decimal_ascii_top b2d_checker u_b2d_checker (.*);
